@@ rtl/cclb_pkg.sv @@
// Shared constants, types and span tables for the cubical cell birth lookup.
`timescale 1ns / 1ps

package cclb_pkg;

   localparam int MAX_X     = 32;
   localparam int MAX_Y     = 32;
   localparam int MAX_Z     = 32;
   localparam int COORD_W   = 5;
   localparam int SIZE_W    = COORD_W + 1;
   localparam int AXIS_SPAN = 1 << COORD_W;
   localparam int VALUE_W   = 16;
   localparam int NUM_BANKS = 8;
   localparam int BANK_SEL_W = 3;
   localparam int BANK_AW   = 3 * (COORD_W - 1);
   localparam int BANK_DEPTH = 1 << BANK_AW;

   localparam logic [VALUE_W-1:0] INF_CODE = {VALUE_W{1'b1}};
   localparam logic [VALUE_W-1:0] SAT_CODE = {{(VALUE_W-1){1'b1}}, 1'b0};

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [1:0] DIM_VERTEX = 2'd0;
   localparam logic [1:0] DIM_EDGE   = 2'd1;
   localparam logic [1:0] DIM_SQUARE = 2'd2;
   localparam logic [1:0] DIM_CUBE   = 2'd3;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_BIRTH  = 2'd1,
      MODE_PARENT = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [COORD_W-1:0]     x;
      logic [COORD_W-1:0]     y;
      logic [COORD_W-1:0]     z;
      logic [1:0]             dim;
      logic [1:0]             orient;
      logic [VALUE_W-1:0]     value;
      logic [NUM_BANKS-1:0]   in_use;
   } query_type;

   typedef logic [NUM_BANKS-1:0][VALUE_W-1:0] bank_data_type;

   // Offsets are coded {dx,dy,dz}; a zero mask marks a bad orientation.
   function automatic logic [NUM_BANKS-1:0] span_mask(input logic [1:0] dim,
                                                      input logic [1:0] orient);
      logic [NUM_BANKS-1:0] m;
      m = '0;
      unique case (dim)
         DIM_VERTEX: m = 8'b0000_0001;
         DIM_EDGE: begin
            unique case (orient)
               AXIS_X:  m = 8'b0001_0001;
               AXIS_Y:  m = 8'b0000_0101;
               AXIS_Z:  m = 8'b0000_0011;
               default: m = '0;
            endcase
         end
         DIM_SQUARE: begin
            unique case (orient)
               AXIS_X:  m = 8'b0000_1111;
               AXIS_Y:  m = 8'b0011_0011;
               AXIS_Z:  m = 8'b0101_0101;
               default: m = '0;
            endcase
         end
         DIM_CUBE: m = 8'b1111_1111;
         default:  m = '0;
      endcase
      return m;
   endfunction

   function automatic logic axis_ok(input logic [SIZE_W-1:0] c,
                                    input logic [SIZE_W-1:0] size,
                                    input int maxv);
      return (c < size) && (int'(c) < maxv) && (int'(c) < AXIS_SPAN);
   endfunction

endpackage

@@ rtl/cclb_ram.sv @@
// One parity bank of the voxel store: one write port, one registered read port.
`timescale 1ns / 1ps

module cclb_ram
   import cclb_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [BANK_AW-1:0] wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [BANK_AW-1:0] rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [BANK_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cclb_resolve.sv @@
// Birth maximum and parent priority search over the spanned voxels, with output register.
`timescale 1ns / 1ps

module cclb_resolve
   import cclb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  query_type            q,
   input  bank_data_type        bank_data,
   output logic                 q_taken,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VALUE_W-1:0]   rsp_birth,
   output logic [SIZE_W-1:0]    rsp_parent_x,
   output logic [SIZE_W-1:0]    rsp_parent_y,
   output logic [SIZE_W-1:0]    rsp_parent_z
);

   logic [VALUE_W-1:0]    vox [NUM_BANKS];
   logic [NUM_BANKS-1:0]  mask;
   logic [BANK_SEL_W-1:0] base_par;
   logic [VALUE_W-1:0]    best;
   logic [BANK_SEL_W-1:0] sel_off;
   logic [VALUE_W-1:0]    birth_in;
   logic [SIZE_W-1:0]     px_in;
   logic [SIZE_W-1:0]     py_in;
   logic [SIZE_W-1:0]     pz_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_birth_ff;
   logic [SIZE_W-1:0]     rsp_px_ff, rsp_py_ff, rsp_pz_ff;

   always_comb begin
      base_par = {q.x[0], q.y[0], q.z[0]};
      mask     = span_mask(q.dim, q.orient);
      for (int o = 0; o < NUM_BANKS; o++) begin
         vox[o] = q.in_use[o] ? bank_data[BANK_SEL_W'(o) ^ base_par] : INF_CODE;
      end
   end

   always_comb begin
      best    = '0;
      sel_off = '0;
      for (int o = 0; o < NUM_BANKS; o++) begin
         if (mask[o] && (vox[o] > best)) begin
            best = vox[o];
         end
         if (mask[o] && (vox[o] == q.value)) begin
            sel_off = BANK_SEL_W'(o);
         end
      end
   end

   always_comb begin
      birth_in = '0;
      px_in    = '0;
      py_in    = '0;
      pz_in    = '0;
      if (q.mode == MODE_BIRTH) begin
         birth_in = (mask == '0) ? INF_CODE : best;
      end else begin
         px_in = {1'b0, q.x} + SIZE_W'(sel_off[2]);
         py_in = {1'b0, q.y} + SIZE_W'(sel_off[1]);
         pz_in = {1'b0, q.z} + SIZE_W'(sel_off[0]);
      end
   end

   assign q_taken = q_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_taken) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_taken) begin
         rsp_birth_ff <= birth_in;
         rsp_px_ff    <= px_in;
         rsp_py_ff    <= py_in;
         rsp_pz_ff    <= pz_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_birth    = rsp_birth_ff;
   assign rsp_parent_x = rsp_px_ff;
   assign rsp_parent_y = rsp_py_ff;
   assign rsp_parent_z = rsp_pz_ff;

endmodule

@@ rtl/cubical_cell_birth_lookup_top.sv @@
// Top level of the cubical cell birth lookup: size registers, banked voxel store, query stage.
//
// The voxel volume lives in eight parity banks, one for each combination of the low bits
// of x, y and z, so the up to eight voxels a cube spans are always read in parallel.
// One transaction is taken per cycle unless a held response stalls the query stage. A load
// writes its bank at acceptance and returns nothing; a birth or parent query reads all banks
// at acceptance into the bank and query registers, is resolved from them into the output
// register and held there until rsp_ready. Voxels beyond size_x, size_y, size_z read as
// 65535; loads saturate at 65534. The store has no reset: read only voxels loaded first.
// Users must write the size registers only while no transaction is in flight (unenforced).
`timescale 1ns / 1ps

module cubical_cell_birth_lookup_top
   import cclb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [COORD_W-1:0]   req_coord_x,
   input  logic [COORD_W-1:0]   req_coord_y,
   input  logic [COORD_W-1:0]   req_coord_z,
   input  logic [1:0]           req_cell_dim,
   input  logic [1:0]           req_cell_orient,
   input  logic [VALUE_W-1:0]   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VALUE_W-1:0]   rsp_birth,
   output logic [SIZE_W-1:0]    rsp_parent_x,
   output logic [SIZE_W-1:0]    rsp_parent_y,
   output logic [SIZE_W-1:0]    rsp_parent_z,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data
);

   logic [SIZE_W-1:0]     size_x_ff, size_y_ff, size_z_ff;
   logic                  s1_valid_ff, s1_valid_in;
   query_type             s1_query_ff;
   query_type             req_query;
   logic                  q_taken;
   logic                  req_accept;
   logic                  is_query;
   logic                  is_load;
   logic [1:0]            ok_x, ok_y, ok_z;
   logic [SIZE_W-1:0]     cx [2];
   logic [SIZE_W-1:0]     cy [2];
   logic [SIZE_W-1:0]     cz [2];
   logic [NUM_BANKS-1:0]  in_use;
   logic [BANK_SEL_W-1:0] base_par;
   logic [VALUE_W-1:0]    load_value;
   logic [BANK_AW-1:0]    rd_addr [NUM_BANKS];
   bank_data_type         bank_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_W'(AXIS_SPAN);
         size_y_ff <= SIZE_W'(AXIS_SPAN);
         size_z_ff <= SIZE_W'(AXIS_SPAN);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_data;
            CSR_SIZE_Y: size_y_ff <= csr_data;
            CSR_SIZE_Z: size_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready  = !s1_valid_ff || q_taken;
   assign req_accept = req_valid && req_ready;
   assign is_query   = (mode_type'(req_mode) == MODE_BIRTH) ||
                       (mode_type'(req_mode) == MODE_PARENT);
   assign base_par   = {req_coord_x[0], req_coord_y[0], req_coord_z[0]};

   always_comb begin
      for (int d = 0; d < 2; d++) begin
         cx[d]   = {1'b0, req_coord_x} + SIZE_W'(d);
         cy[d]   = {1'b0, req_coord_y} + SIZE_W'(d);
         cz[d]   = {1'b0, req_coord_z} + SIZE_W'(d);
         ok_x[d] = axis_ok(cx[d], size_x_ff, MAX_X);
         ok_y[d] = axis_ok(cy[d], size_y_ff, MAX_Y);
         ok_z[d] = axis_ok(cz[d], size_z_ff, MAX_Z);
      end
      for (int o = 0; o < NUM_BANKS; o++) begin
         in_use[o] = ok_x[o[2]] && ok_y[o[1]] && ok_z[o[0]];
      end
   end

   // Bank b holds the spanned voxel whose offset is b xor the base parity.
   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         rd_addr[b] = {cx[b[2] ^ base_par[2]][COORD_W-1:1],
                       cy[b[1] ^ base_par[1]][COORD_W-1:1],
                       cz[b[0] ^ base_par[0]][COORD_W-1:1]};
      end
   end

   assign is_load    = req_accept && (mode_type'(req_mode) == MODE_LOAD) && in_use[0];
   assign load_value = (req_value > SAT_CODE) ? SAT_CODE : req_value;

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      cclb_ram u_ram (
         .clock   (clock),
         .wr_en   (is_load && (base_par == BANK_SEL_W'(b))),
         .wr_addr ({req_coord_x[COORD_W-1:1], req_coord_y[COORD_W-1:1],
                    req_coord_z[COORD_W-1:1]}),
         .wr_data (load_value),
         .rd_en   (req_accept && is_query),
         .rd_addr (rd_addr[b]),
         .rd_data (bank_data[b])
      );
   end

   always_comb begin
      req_query.mode   = mode_type'(req_mode);
      req_query.x      = req_coord_x;
      req_query.y      = req_coord_y;
      req_query.z      = req_coord_z;
      req_query.dim    = req_cell_dim;
      req_query.orient = req_cell_orient;
      req_query.value  = req_value;
      req_query.in_use = in_use;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept && is_query) begin
         s1_valid_in = 1'b1;
      end else if (q_taken) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && is_query) begin
         s1_query_ff <= req_query;
      end
   end

   cclb_resolve u_resolve (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (s1_valid_ff),
      .q            (s1_query_ff),
      .bank_data    (bank_data),
      .q_taken      (q_taken),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_birth    (rsp_birth),
      .rsp_parent_x (rsp_parent_x),
      .rsp_parent_y (rsp_parent_y),
      .rsp_parent_z (rsp_parent_z)
   );

endmodule
